// ===== rtl/mmfc_pkg.sv =====
// Shared types and constants for the mount motion and fault controller.
`default_nettype none
package mmfc_pkg;

    typedef enum logic [2:0] {
        MODE_STOP      = 3'd0,
        MODE_DOWN      = 3'd1,
        MODE_UP        = 3'd2,
        MODE_RIGHT     = 3'd3,
        MODE_LEFT      = 3'd4,
        MODE_AUTO_UP   = 3'd5,
        MODE_AUTO_DOWN = 3'd6,
        MODE_FAULT     = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        DRV_STOP  = 3'd0,
        DRV_UP    = 3'd1,
        DRV_DOWN  = 3'd2,
        DRV_LEFT  = 3'd3,
        DRV_RIGHT = 3'd4
    } drive_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_FAULT     = 4'd1,
        EV_TOP       = 4'd2,
        EV_BOTTOM    = 4'd3,
        EV_LEFT_LIM  = 4'd4,
        EV_RIGHT_LIM = 4'd5,
        EV_TV_ON     = 4'd6,
        EV_TV_OFF    = 4'd7,
        EV_BTN_UP    = 4'd8,
        EV_BTN_DOWN  = 4'd9,
        EV_BTN_LEFT  = 4'd10,
        EV_BTN_RIGHT = 4'd11
    } event_t;

    typedef enum logic [2:0] {
        CFG_UP_LIM    = 3'd0,
        CFG_DOWN_LIM  = 3'd1,
        CFG_LEFT_LIM  = 3'd2,
        CFG_RIGHT_LIM = 3'd3,
        CFG_OVER_MS   = 3'd4,
        CFG_ZERO_MS   = 3'd5,
        CFG_TV_MS     = 3'd6,
        CFG_HOLD_MS   = 3'd7
    } cfg_idx_t;

    localparam logic [3:0] BTN_UP    = 4'd8;
    localparam logic [3:0] BTN_DOWN  = 4'd4;
    localparam logic [3:0] BTN_LEFT  = 4'd2;
    localparam logic [3:0] BTN_RIGHT = 4'd1;

    localparam logic [9:0] ZERO_CURRENT_LEVEL = 10'd2;

    localparam int IN_BYTES  = 8;
    localparam int OUT_BYTES = 2;

    typedef struct packed {
        logic [9:0]  up_lim;
        logic [9:0]  down_lim;
        logic [9:0]  left_lim;
        logic [9:0]  right_lim;
        logic [15:0] over_ms;
        logic [15:0] zero_ms;
        logic [15:0] tv_ms;
        logic [15:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  vertical_current;
        logic [9:0]  horizontal_current;
        logic        up_allowed;
        logic        down_allowed;
        logic        left_allowed;
        logic        right_allowed;
        logic        near_wall;
        logic        tv_level;
        logic        button_valid;
        logic [3:0]  button_code;
    } item_t;

    typedef struct packed {
        mode_t  mode;
        drive_t drive;
        logic   slow_duty;
        logic   restart_pulse;
        logic   fault_lamp;
        event_t event_code;
        logic   entered_ok;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/mmfc_detect.sv =====
// Event detectors: overcurrent and zero-current timers, limit edges, TV debounce, remote.
`default_nettype none
module mmfc_detect (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire mmfc_pkg::item_t item,
    input  wire mmfc_pkg::mode_t mode,
    input  wire mmfc_pkg::cfg_t  cfg,
    output mmfc_pkg::event_t     event_code
);

    logic        vert_armed_reg, vert_armed_next;
    logic [31:0] vert_start_reg, vert_start_next;
    logic        horiz_armed_reg, horiz_armed_next;
    logic [31:0] horiz_start_reg, horiz_start_next;
    logic        zero_armed_reg, zero_armed_next;
    logic [31:0] zero_start_reg, zero_start_next;
    logic        tv_armed_reg, tv_armed_next;
    logic [31:0] tv_start_reg, tv_start_next;
    logic        tv_settled_reg, tv_settled_next;
    logic [2:0]  prev_allowed_reg;
    logic        primed_reg;

    logic        vert_mode, horiz_mode, zero_mode;
    logic [9:0]  v_lim, h_lim;
    logic [31:0] v_el, h_el, z_el, t_el;
    logic        v_fire, h_fire, z_fire, t_fire;
    logic [2:0]  cur_allowed, prev_eff;
    logic        tv_ref;
    logic        top_ev, left_ev, right_ev;
    mmfc_pkg::event_t btn_ev;

    always_comb begin
        vert_mode = (mode == mmfc_pkg::MODE_DOWN) || (mode == mmfc_pkg::MODE_UP) ||
                    (mode == mmfc_pkg::MODE_AUTO_UP) || (mode == mmfc_pkg::MODE_AUTO_DOWN);
        horiz_mode = (mode == mmfc_pkg::MODE_RIGHT) || (mode == mmfc_pkg::MODE_LEFT);
        zero_mode = (mode == mmfc_pkg::MODE_DOWN) || (mode == mmfc_pkg::MODE_AUTO_DOWN);
        v_lim = ((mode == mmfc_pkg::MODE_UP) || (mode == mmfc_pkg::MODE_AUTO_UP)) ?
                cfg.up_lim : cfg.down_lim;
        h_lim = (mode == mmfc_pkg::MODE_RIGHT) ? cfg.right_lim : cfg.left_lim;
        v_el = item.now_ms - vert_start_reg;
        h_el = item.now_ms - horiz_start_reg;
        z_el = item.now_ms - zero_start_reg;
        t_el = item.now_ms - tv_start_reg;

        // Vertical overcurrent timer.
        vert_armed_next = vert_armed_reg;
        vert_start_next = vert_start_reg;
        v_fire = 1'b0;
        if (!vert_mode) begin
            vert_armed_next = 1'b0;
        end else if (item.vertical_current >= v_lim) begin
            if (!vert_armed_reg) begin
                vert_armed_next = 1'b1;
                vert_start_next = item.now_ms;
            end else if (v_el > {16'd0, cfg.over_ms}) begin
                vert_armed_next = 1'b0;
                v_fire = 1'b1;
            end
        end

        // Horizontal overcurrent timer.
        horiz_armed_next = horiz_armed_reg;
        horiz_start_next = horiz_start_reg;
        h_fire = 1'b0;
        if (!horiz_mode) begin
            horiz_armed_next = 1'b0;
        end else if (item.horizontal_current >= h_lim) begin
            if (!horiz_armed_reg) begin
                horiz_armed_next = 1'b1;
                horiz_start_next = item.now_ms;
            end else if (h_el > {16'd0, cfg.over_ms}) begin
                horiz_armed_next = 1'b0;
                h_fire = 1'b1;
            end
        end

        // Bottom detection by sustained near-zero current while moving down.
        zero_armed_next = zero_armed_reg;
        zero_start_next = zero_start_reg;
        z_fire = 1'b0;
        if (!zero_mode) begin
            zero_armed_next = 1'b0;
        end else if (item.vertical_current <= mmfc_pkg::ZERO_CURRENT_LEVEL) begin
            if (!zero_armed_reg) begin
                zero_armed_next = 1'b1;
                zero_start_next = item.now_ms;
            end else if (z_el > {16'd0, cfg.zero_ms}) begin
                zero_armed_next = 1'b0;
                z_fire = 1'b1;
            end
        end

        // The first item after reset seeds the edge and TV references.
        cur_allowed = {item.right_allowed, item.left_allowed, item.up_allowed};
        prev_eff = primed_reg ? prev_allowed_reg : cur_allowed;
        tv_ref = primed_reg ? tv_settled_reg : item.tv_level;
        top_ev = !item.up_allowed && prev_eff[0];
        left_ev = !item.left_allowed && prev_eff[1];
        right_ev = !item.right_allowed && prev_eff[2];

        tv_armed_next = tv_armed_reg;
        tv_start_next = tv_start_reg;
        tv_settled_next = tv_ref;
        t_fire = 1'b0;
        if (item.tv_level != tv_ref) begin
            if (!tv_armed_reg) begin
                tv_armed_next = 1'b1;
                tv_start_next = item.now_ms;
            end else if (t_el > {16'd0, cfg.tv_ms}) begin
                t_fire = 1'b1;
                tv_settled_next = item.tv_level;
                tv_armed_next = 1'b0;
            end
        end else begin
            tv_armed_next = 1'b0;
        end

        btn_ev = mmfc_pkg::EV_NONE;
        if (item.button_valid) begin
            priority case (item.button_code)
                mmfc_pkg::BTN_UP:    btn_ev = mmfc_pkg::EV_BTN_UP;
                mmfc_pkg::BTN_DOWN:  btn_ev = mmfc_pkg::EV_BTN_DOWN;
                mmfc_pkg::BTN_LEFT:  btn_ev = mmfc_pkg::EV_BTN_LEFT;
                mmfc_pkg::BTN_RIGHT: btn_ev = mmfc_pkg::EV_BTN_RIGHT;
                default:             btn_ev = mmfc_pkg::EV_NONE;
            endcase
        end

        priority if (v_fire || h_fire) begin
            event_code = mmfc_pkg::EV_FAULT;
        end else if (top_ev) begin
            event_code = mmfc_pkg::EV_TOP;
        end else if (z_fire) begin
            event_code = mmfc_pkg::EV_BOTTOM;
        end else if (left_ev) begin
            event_code = mmfc_pkg::EV_LEFT_LIM;
        end else if (right_ev) begin
            event_code = mmfc_pkg::EV_RIGHT_LIM;
        end else if (t_fire) begin
            event_code = item.tv_level ? mmfc_pkg::EV_TV_ON : mmfc_pkg::EV_TV_OFF;
        end else begin
            event_code = btn_ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vert_armed_reg <= 1'b0;
            horiz_armed_reg <= 1'b0;
            zero_armed_reg <= 1'b0;
            tv_armed_reg <= 1'b0;
            primed_reg <= 1'b0;
        end else if (en) begin
            vert_armed_reg <= vert_armed_next;
            horiz_armed_reg <= horiz_armed_next;
            zero_armed_reg <= zero_armed_next;
            tv_armed_reg <= tv_armed_next;
            primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vert_start_reg <= vert_start_next;
            horiz_start_reg <= horiz_start_next;
            zero_start_reg <= zero_start_next;
            tv_start_reg <= tv_start_next;
            tv_settled_reg <= tv_settled_next;
            prev_allowed_reg <= cur_allowed;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mmfc_mode.sv =====
// Mode transition table, entry checks, fault hold timer and result formation.
`default_nettype none
module mmfc_mode (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire mmfc_pkg::item_t  item,
    input  wire mmfc_pkg::event_t event_code,
    input  wire mmfc_pkg::cfg_t   cfg,
    output mmfc_pkg::mode_t       mode,
    output mmfc_pkg::result_t     result
);

    mmfc_pkg::mode_t mode_reg, mode_next;
    logic [31:0]     release_reg, release_next;
    logic [31:0]     remain;
    mmfc_pkg::mode_t want;
    mmfc_pkg::drive_t drive;
    logic            slow;

    function automatic mmfc_pkg::mode_t table_next(input mmfc_pkg::mode_t m,
                                                   input mmfc_pkg::event_t ev);
        mmfc_pkg::mode_t r;
        r = mmfc_pkg::MODE_STOP;
        unique case (m)
            mmfc_pkg::MODE_STOP: begin
                priority case (ev)
                    mmfc_pkg::EV_TV_OFF:    r = mmfc_pkg::MODE_AUTO_UP;
                    mmfc_pkg::EV_BTN_UP:    r = mmfc_pkg::MODE_UP;
                    mmfc_pkg::EV_TV_ON:     r = mmfc_pkg::MODE_AUTO_DOWN;
                    mmfc_pkg::EV_BTN_DOWN:  r = mmfc_pkg::MODE_DOWN;
                    mmfc_pkg::EV_BTN_LEFT:  r = mmfc_pkg::MODE_LEFT;
                    mmfc_pkg::EV_BTN_RIGHT: r = mmfc_pkg::MODE_RIGHT;
                    default:                r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_DOWN: begin
                priority case (ev)
                    mmfc_pkg::EV_FAULT:    r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_TV_OFF:   r = mmfc_pkg::MODE_AUTO_UP;
                    mmfc_pkg::EV_BTN_DOWN: r = mmfc_pkg::MODE_DOWN;
                    default:               r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_UP: begin
                priority case (ev)
                    mmfc_pkg::EV_FAULT:  r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_BTN_UP: r = mmfc_pkg::MODE_UP;
                    default:             r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_RIGHT: begin
                priority case (ev)
                    mmfc_pkg::EV_FAULT:     r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_BTN_RIGHT: r = mmfc_pkg::MODE_RIGHT;
                    default:                r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_LEFT: begin
                priority case (ev)
                    mmfc_pkg::EV_FAULT:    r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_BTN_LEFT: r = mmfc_pkg::MODE_LEFT;
                    default:               r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_AUTO_UP: begin
                priority case (ev)
                    mmfc_pkg::EV_NONE:   r = mmfc_pkg::MODE_AUTO_UP;
                    mmfc_pkg::EV_TV_OFF: r = mmfc_pkg::MODE_AUTO_UP;
                    mmfc_pkg::EV_FAULT:  r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_TV_ON:  r = mmfc_pkg::MODE_AUTO_DOWN;
                    default:             r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_AUTO_DOWN: begin
                priority case (ev)
                    mmfc_pkg::EV_NONE:   r = mmfc_pkg::MODE_AUTO_DOWN;
                    mmfc_pkg::EV_TV_ON:  r = mmfc_pkg::MODE_AUTO_DOWN;
                    mmfc_pkg::EV_FAULT:  r = mmfc_pkg::MODE_FAULT;
                    mmfc_pkg::EV_TV_OFF: r = mmfc_pkg::MODE_AUTO_UP;
                    default:             r = mmfc_pkg::MODE_STOP;
                endcase
            end
            mmfc_pkg::MODE_FAULT: r = mmfc_pkg::MODE_STOP;
        endcase
        return r;
    endfunction

    always_comb begin
        // The fault hold lasts while the release time is still ahead by less than half the wrap.
        remain = release_reg - item.now_ms;
        if (mode_reg == mmfc_pkg::MODE_FAULT) begin
            want = ((remain != 32'd0) && !remain[31]) ? mmfc_pkg::MODE_FAULT :
                   mmfc_pkg::MODE_STOP;
        end else begin
            want = table_next(mode_reg, event_code);
        end

        mode_next = mmfc_pkg::MODE_STOP;
        drive = mmfc_pkg::DRV_STOP;
        slow = 1'b0;
        release_next = release_reg;
        unique case (want)
            mmfc_pkg::MODE_DOWN, mmfc_pkg::MODE_AUTO_DOWN: begin
                if (item.down_allowed) begin
                    mode_next = want;
                    drive = mmfc_pkg::DRV_DOWN;
                    slow = item.near_wall;
                end
            end
            mmfc_pkg::MODE_UP, mmfc_pkg::MODE_AUTO_UP: begin
                if (item.up_allowed) begin
                    mode_next = want;
                    drive = mmfc_pkg::DRV_UP;
                    slow = item.near_wall;
                end
            end
            mmfc_pkg::MODE_RIGHT: begin
                if (item.right_allowed) begin
                    mode_next = want;
                    drive = mmfc_pkg::DRV_RIGHT;
                end
            end
            mmfc_pkg::MODE_LEFT: begin
                if (item.left_allowed) begin
                    mode_next = want;
                    drive = mmfc_pkg::DRV_LEFT;
                end
            end
            mmfc_pkg::MODE_FAULT: begin
                if (mode_reg != mmfc_pkg::MODE_FAULT) begin
                    release_next = item.now_ms + {16'd0, cfg.hold_ms};
                end
                mode_next = mmfc_pkg::MODE_FAULT;
            end
            mmfc_pkg::MODE_STOP: mode_next = mmfc_pkg::MODE_STOP;
        endcase

        result.mode = mode_next;
        result.drive = drive;
        result.slow_duty = slow;
        result.restart_pulse = (mode_next != mmfc_pkg::MODE_STOP) &&
                               (mode_next != mmfc_pkg::MODE_FAULT) &&
                               (mode_next != mode_reg);
        result.fault_lamp = (mode_next == mmfc_pkg::MODE_FAULT);
        result.event_code = event_code;
        result.entered_ok = (mode_next == want);
    end

    assign mode = mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mmfc_pkg::MODE_STOP;
            release_reg <= 32'd0;
        end else if (en) begin
            mode_reg <= mode_next;
            release_reg <= release_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mount_motion_fault_controller.sv =====
// A request accepted into the input register passes to the output register once the output is free.
// Throughput: one request per cycle unless the output stalls; the input register refills whenever the result moves on.
// The mode and detector state feed back through compare and subtract logic.
// Reset (aresetn low, synchronous): both channels empty, mode stopped, timers disarmed,
// configuration back to its defaults; TV and permit references load from the next request.
`default_nettype none
module mount_motion_fault_controller (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // now_ms[31:0], vertical_current[41:32], horizontal_current[51:42], up_allowed[52],
    // down_allowed[53], left_allowed[54], right_allowed[55], near_wall[56], tv_level[57],
    // button_valid[58], button_code[62:59], zero[63]
    input  wire logic [8*mmfc_pkg::IN_BYTES-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // mode[2:0], drive[5:3], slow_duty[6], restart_pulse[7], fault_lamp[8],
    // event_code[12:9], entered_ok[13], zero[15:14]
    output logic [8*mmfc_pkg::OUT_BYTES-1:0] m_tdata,
    input  wire logic                    cfg_wr_en,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [15:0]             cfg_wdata
);

    mmfc_pkg::cfg_t    cfg_reg;
    mmfc_pkg::item_t   item_reg, item_in;
    logic              in_vld_reg;
    logic              out_vld_reg;
    mmfc_pkg::result_t out_reg;
    mmfc_pkg::result_t result;
    mmfc_pkg::event_t  event_code;
    mmfc_pkg::mode_t   mode;
    logic              advance;

    always_comb begin
        item_in.now_ms = s_tdata[31:0];
        item_in.vertical_current = s_tdata[41:32];
        item_in.horizontal_current = s_tdata[51:42];
        item_in.up_allowed = s_tdata[52];
        item_in.down_allowed = s_tdata[53];
        item_in.left_allowed = s_tdata[54];
        item_in.right_allowed = s_tdata[55];
        item_in.near_wall = s_tdata[56];
        item_in.tv_level = s_tdata[57];
        item_in.button_valid = s_tdata[58];
        item_in.button_code = s_tdata[62:59];
    end

    assign advance = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.up_lim <= 10'd1023;
            cfg_reg.down_lim <= 10'd1023;
            cfg_reg.left_lim <= 10'd1023;
            cfg_reg.right_lim <= 10'd1023;
            cfg_reg.over_ms <= 16'd500;
            cfg_reg.zero_ms <= 16'd500;
            cfg_reg.tv_ms <= 16'd1000;
            cfg_reg.hold_ms <= 16'd5000;
        end else if (cfg_wr_en) begin
            unique case (mmfc_pkg::cfg_idx_t'(cfg_index))
                mmfc_pkg::CFG_UP_LIM:    cfg_reg.up_lim <= cfg_wdata[9:0];
                mmfc_pkg::CFG_DOWN_LIM:  cfg_reg.down_lim <= cfg_wdata[9:0];
                mmfc_pkg::CFG_LEFT_LIM:  cfg_reg.left_lim <= cfg_wdata[9:0];
                mmfc_pkg::CFG_RIGHT_LIM: cfg_reg.right_lim <= cfg_wdata[9:0];
                mmfc_pkg::CFG_OVER_MS:   cfg_reg.over_ms <= cfg_wdata;
                mmfc_pkg::CFG_ZERO_MS:   cfg_reg.zero_ms <= cfg_wdata;
                mmfc_pkg::CFG_TV_MS:     cfg_reg.tv_ms <= cfg_wdata;
                mmfc_pkg::CFG_HOLD_MS:   cfg_reg.hold_ms <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    mmfc_detect u_detect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .item       (item_reg),
        .mode       (mode),
        .cfg        (cfg_reg),
        .event_code (event_code)
    );

    mmfc_mode u_mode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .item       (item_reg),
        .event_code (event_code),
        .cfg        (cfg_reg),
        .mode       (mode),
        .result     (result)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {2'b00, out_reg.entered_ok, out_reg.event_code, out_reg.fault_lamp,
                      out_reg.restart_pulse, out_reg.slow_duty, out_reg.drive, out_reg.mode};

endmodule
`default_nettype wire

// ===== rtl/mmfc_checker.sv =====
// Port-level checks for the controller, bound to the top level.
`default_nettype none
module mmfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    logic [2:0] mode_f;
    logic [2:0] drive_f;
    logic       restart_f;
    logic       led_f;
    logic [3:0] event_f;

    assign mode_f = m_tdata[2:0];
    assign drive_f = m_tdata[5:3];
    assign restart_f = m_tdata[7];
    assign led_f = m_tdata[8];
    assign event_f = m_tdata[12:9];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (led_f == (mode_f == mmfc_pkg::MODE_FAULT)))
        else $error("fault LED disagrees with mode");

    a_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((drive_f == mmfc_pkg::DRV_STOP) ==
                      ((mode_f == mmfc_pkg::MODE_STOP) || (mode_f == mmfc_pkg::MODE_FAULT))))
        else $error("drive command disagrees with mode");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && restart_f |-> (mode_f != mmfc_pkg::MODE_STOP) &&
                                  (mode_f != mmfc_pkg::MODE_FAULT) &&
                                  (event_f != mmfc_pkg::EV_FAULT))
        else $error("restart pulse without a move");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mount_motion_fault_controller mmfc_checker u_mmfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
